// File: hdl/stream_find_replace_core_assert.svh
// ----------------------------------------------------------------------------
// Stream find/replace assertion macros
// Immediate-report concurrent checks, compiled out for synthesis.
// Each macro expects clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_REPLACE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SFR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFR_ASSERT(label, ante, cons, msg)
`define SFR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, register codes, control types and the case fold function.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIN_DEPTH  = 8;   // largest window the pattern field allows
    localparam int REPL_BYTES = 8;   // largest replacement
    localparam int CNT_W      = 4;   // holds 0..15; counts use 0..8
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIND_PATTERN    = CFG_IDX_W'(0),
        REG_FIND_LENGTH     = CFG_IDX_W'(1),
        REG_REPLACE_PATTERN = CFG_IDX_W'(2),
        REG_REPLACE_LENGTH  = CFG_IDX_W'(3),
        REG_IGNORE_CASE     = CFG_IDX_W'(4)
    } sfr_reg_t;

    // broadcast control to every window cell
    typedef struct packed {
        logic write;    // selected cell takes the incoming byte
        logic shift;    // every cell takes its upper neighbor's byte
        logic fold_en;  // compare letters without case
    } sfr_cell_ctl_t;

    // result group handed to the emitter
    typedef struct packed {
        logic                                 valid;
        logic [CNT_W-1:0]                     cnt;
        logic [REPL_BYTES-1:0][BYTE_W-1:0]    data;
    } sfr_load_t;

    // upper-case ASCII to lower case when enabled
    function automatic logic [BYTE_W-1:0] sfr_fold(input logic [BYTE_W-1:0] c,
                                                   input logic              en);
        logic [BYTE_W-1:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels: text input, edited text output, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window position: holds a byte, compares it against its pattern byte
// and passes its view down the chain on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire sfr_cell_ctl_t     ctl,
    input  wire logic              sel,        // this cell is the append slot
    input  wire logic              active,     // position lies inside the pattern
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic [BYTE_W-1:0] nbr_view,   // view of the next cell up
    input  wire logic              match_in,
    output logic      [BYTE_W-1:0] view,
    output logic                   match_out
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              eq;

    // window content including the byte being appended
    assign view = sel ? in_byte : byte_reg;

    // compare and extend the match chain
    assign eq        = (sfr_fold(view, ctl.fold_en) == sfr_fold(pat_byte, ctl.fold_en));
    assign match_out = match_in && (!active || eq);

    // next byte: shift down, append, or hold
    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.shift)
        begin
            byte_next = nbr_view;
        end
        else if (ctl.write && sel)
        begin
            byte_next = in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// File: hdl/sfr_emit.sv
// ----------------------------------------------------------------------------
// sfr_emit
// Result queue of up to eight bytes feeding a registered output stage.
// A new group loads when the queue is empty or hands off its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_find_replace_core_assert.svh"

module sfr_emit import sfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sfr_load_t ld,
    output logic           can_load,
    sfr_out_if.source      text_out
);

    logic [REPL_BYTES-1:0][BYTE_W-1:0] slot_reg;
    logic [REPL_BYTES-1:0][BYTE_W-1:0] slot_next;
    logic [CNT_W-1:0]                  q_cnt_reg;
    logic [CNT_W-1:0]                  q_cnt_next;
    logic                              ov_reg;
    logic                              ov_next;
    logic [BYTE_W-1:0]                 ob_reg;
    logic [BYTE_W-1:0]                 ob_next;
    logic                              last_reg;
    logic                              last_next;
    logic                              pop;
    logic                              load_go;

    // queue head moves to the output stage when that stage is empty or its byte is taken
    assign pop      = (q_cnt_reg != '0) && (!ov_reg || text_out.ready);
    assign can_load = (q_cnt_reg == '0) || ((q_cnt_reg == CNT_W'(1)) && pop);
    assign load_go  = ld.valid && (ld.cnt != '0);

    // queue update
    always_comb
    begin
        slot_next  = slot_reg;
        q_cnt_next = q_cnt_reg;
        if (load_go)
        begin
            slot_next  = ld.data;
            q_cnt_next = ld.cnt;
        end
        else if (pop)
        begin
            slot_next  = {BYTE_W'(0), slot_reg[REPL_BYTES-1:1]};
            q_cnt_next = q_cnt_reg - CNT_W'(1);
        end
    end

    // output stage update
    always_comb
    begin
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        last_next = last_reg;
        if (pop)
        begin
            ov_next   = 1'b1;
            ob_next   = slot_reg[0];
            last_next = (q_cnt_reg == CNT_W'(1));
        end
        else if (text_out.ready)
        begin
            ov_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        ob_reg   <= ob_next;
        last_reg <= last_next;
    end

    assign text_out.valid    = ov_reg;
    assign text_out.out_byte = ob_reg;
    assign text_out.run_last = last_reg;

    // checks
    `SFR_ASSERT(a_qcnt_range, 1'b1, q_cnt_reg <= CNT_W'(REPL_BYTES), "queue count out of range")
    `SFR_ASSERT(a_load_room, ld.valid, can_load, "group loaded while queue busy")
    `SFR_ASSERT_NEXT(a_load_count, load_go, q_cnt_reg == $past(ld.cnt), "queue count not loaded")

endmodule

`default_nettype wire

// File: hdl/stream_find_replace_core.sv
// Stream find/replace: an item's results go from the result queue to a registered output stage.
// Items with at most one result are taken one per cycle while the output is ready; an item with n results
// holds the input while the result queue drains, one byte a cycle while the output is ready.
// The window compare is a chain of per-byte cells, one compare step per cell.
// Reset zeroes the configuration registers and empties window and queue; no clearing pass.
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Replaces leftmost non-overlapping occurrences of a byte pattern in a stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_find_replace_core_assert.svh"

module stream_find_replace_core import sfr_pkg::*;
#(
    parameter int PATTERN_BYTES = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfr_cfg_if.sink   cfg,
    sfr_in_if.sink    text_in,
    sfr_out_if.source text_out
);

    localparam int WIN_CELLS = (PATTERN_BYTES < WIN_DEPTH) ? PATTERN_BYTES : WIN_DEPTH;

    // configuration registers
    logic [WIN_DEPTH-1:0][BYTE_W-1:0]  find_reg;
    logic [WIN_DEPTH-1:0][BYTE_W-1:0]  find_next;
    logic [CNT_W-1:0]                  flen_reg;
    logic [CNT_W-1:0]                  flen_next;
    logic [REPL_BYTES-1:0][BYTE_W-1:0] repl_reg;
    logic [REPL_BYTES-1:0][BYTE_W-1:0] repl_next;
    logic [CNT_W-1:0]                  rlen_reg;
    logic [CNT_W-1:0]                  rlen_next;
    logic                              icase_reg;
    logic                              icase_next;

    logic [CNT_W-1:0]                  win_cnt_reg;
    logic [CNT_W-1:0]                  win_cnt_next;

    logic                              cfg_we;
    logic                              accept;
    logic [CNT_W-1:0]                  len;
    logic [CNT_W-1:0]                  rlen;
    logic                              len_zero;
    logic [CNT_W-1:0]                  cnt_eff;
    logic [CNT_W-1:0]                  cnt_inc;
    logic                              full;
    logic                              match;
    logic                              can_load;
    sfr_cell_ctl_t                     ctl;
    sfr_load_t                         ld;

    logic [BYTE_W-1:0]                 view [WIN_CELLS];
    logic [WIN_CELLS:0]                mchain;
    logic [REPL_BYTES-1:0][BYTE_W-1:0] win_data;

    assign cfg.ready    = 1'b1;
    assign cfg_we       = cfg.valid && cfg.ready;
    assign text_in.ready = can_load;
    assign accept       = text_in.valid && text_in.ready;

    // register write decode
    always_comb
    begin
        find_next  = find_reg;
        flen_next  = flen_reg;
        repl_next  = repl_reg;
        rlen_next  = rlen_reg;
        icase_next = icase_reg;
        if (cfg_we)
        begin
            unique case (cfg.index)
                REG_FIND_PATTERN:    find_next  = cfg.data;
                REG_FIND_LENGTH:     flen_next  = cfg.data[CNT_W-1:0];
                REG_REPLACE_PATTERN: repl_next  = cfg.data;
                REG_REPLACE_LENGTH:  rlen_next  = cfg.data[CNT_W-1:0];
                REG_IGNORE_CASE:     icase_next = cfg.data[0];
                default:             ;
            endcase
        end
    end

    // effective lengths
    assign len  = (flen_reg > CNT_W'(WIN_CELLS)) ? CNT_W'(WIN_CELLS) : flen_reg;
    assign rlen = (rlen_reg > CNT_W'(REPL_BYTES)) ? CNT_W'(REPL_BYTES) : rlen_reg;
    assign len_zero = (len == '0);

    // append position and window-full test
    assign cnt_eff = (win_cnt_reg >= len) ? '0 : win_cnt_reg;
    assign cnt_inc = cnt_eff + CNT_W'(1);
    assign full    = (cnt_inc == len);
    assign match   = full && mchain[WIN_CELLS];

    // cell control
    assign ctl.fold_en = icase_reg;
    assign ctl.shift   = accept && !len_zero && full && !match && !text_in.stream_end;
    assign ctl.write   = accept && !len_zero && !ctl.shift;

    // window cells
    assign mchain[0] = 1'b1;
    for (genvar i = 0; i < WIN_CELLS; i++)
    begin : g_cell
        logic [BYTE_W-1:0] nbr;
        if (i == WIN_CELLS - 1)
        begin : g_top
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = view[i+1];
        end

        sfr_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .sel       (cnt_eff == CNT_W'(i)),
            .active    (CNT_W'(i) < len),
            .in_byte   (text_in.in_byte),
            .pat_byte  (find_reg[i]),
            .nbr_view  (nbr),
            .match_in  (mchain[i]),
            .view      (view[i]),
            .match_out (mchain[i+1])
        );
    end

    // window bytes in order, padded to the queue width
    for (genvar j = 0; j < REPL_BYTES; j++)
    begin : g_wdata
        if (j < WIN_CELLS)
        begin : g_cell_byte
            assign win_data[j] = view[j];
        end
        else
        begin : g_pad
            assign win_data[j] = '0;
        end
    end

    // result group for this item
    always_comb
    begin
        ld.valid = accept;
        ld.cnt   = '0;
        ld.data  = win_data;
        if (len_zero)
        begin
            ld.cnt     = CNT_W'(1);
            ld.data    = '0;
            ld.data[0] = text_in.in_byte;
        end
        else if (match)
        begin
            ld.cnt  = rlen;
            ld.data = repl_reg;
        end
        else if (full)
        begin
            ld.cnt = text_in.stream_end ? len : CNT_W'(1);
        end
        else
        begin
            ld.cnt = text_in.stream_end ? cnt_inc : '0;
        end
    end

    // window fill count
    always_comb
    begin
        win_cnt_next = win_cnt_reg;
        if (cfg_we && (cfg.index == REG_FIND_LENGTH))
        begin
            win_cnt_next = '0;
        end
        else if (accept && !len_zero)
        begin
            if (text_in.stream_end || match)
            begin
                win_cnt_next = '0;
            end
            else if (full)
            begin
                win_cnt_next = cnt_eff;
            end
            else
            begin
                win_cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_reg    <= '0;
            flen_reg    <= '0;
            repl_reg    <= '0;
            rlen_reg    <= '0;
            icase_reg   <= 1'b0;
            win_cnt_reg <= '0;
        end
        else
        begin
            find_reg    <= find_next;
            flen_reg    <= flen_next;
            repl_reg    <= repl_next;
            rlen_reg    <= rlen_next;
            icase_reg   <= icase_next;
            win_cnt_reg <= win_cnt_next;
        end
    end

    // result queue and output stage
    sfr_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .can_load (can_load),
        .text_out (text_out)
    );

    // checks
    `SFR_ASSERT(a_win_bound, 1'b1, (win_cnt_reg == '0) || (win_cnt_reg < len), "window overfull")
    `SFR_ASSERT_NEXT(a_end_flush, accept && text_in.stream_end, win_cnt_reg == '0, "window kept after end")
    `SFR_ASSERT_NEXT(a_shift_cnt, ctl.shift, win_cnt_reg == $past(len) - CNT_W'(1), "bad count after shift")

endmodule

`default_nettype wire
